// File: rtl/icd_pkg.sv
package icd_pkg;

  // fixed geometry of the ports
  localparam int unsigned LANES        = 4;
  localparam int unsigned WINDOW_DEPTH = 4;
  localparam int unsigned WIN_IDX_W    = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SAMPLE_W     = 12;
  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned CHANNELS_DEF = 4;
  localparam int unsigned THR_W        = 16;
  localparam int unsigned HIST_W       = 8;
  localparam int unsigned DELTA_W      = 15;
  localparam int unsigned FLAGS_W      = LANES;
  localparam int unsigned WIDE_W       = 18;
  localparam int unsigned SCALE_SHIFT  = 4;
  localparam int unsigned CFG_IDX_W    = $clog2(2 * LANES);

  localparam int unsigned IN_DATA_W  = LANES * SAMPLE_W;
  localparam int unsigned OUT_DATA_W = FLAGS_W + LANES * HIST_W + LANES * DELTA_W;

  localparam logic [WIDE_W-1:0]  DARK_LIMIT = WIDE_W'(2048);
  localparam logic [DELTA_W-1:0] DELTA_MAX  = {DELTA_W{1'b1}};

  // config register map
  localparam logic [CFG_IDX_W-1:0] REG_ON_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OFF_BASE = CFG_IDX_W'(LANES);

  typedef enum logic [1:0] {
    REQ_ON_SAMPLES  = 2'd0,
    REQ_OFF_SAMPLES = 2'd1,
    REQ_EVALUATE    = 2'd2,
    REQ_IDLE        = 2'd3
  } req_t;

  // per-request controls shared by all lanes
  typedef struct packed {
    logic                 take_on;
    logic                 take_off;
    logic                 eval;
    logic [WIN_IDX_W-1:0] slot;
  } lane_ctrl_t;

endpackage

// File: rtl/icd_lane.sv
module icd_lane import icd_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lane_ctrl_t             ctrl,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [THR_W-1:0]       on_thr,
  input  logic [THR_W-1:0]       off_thr,
  output logic [HIST_W-1:0]      history_nxt,
  output logic [DELTA_W-1:0]     delta_nxt
);

  localparam int unsigned SUM_W = SAMPLE_BITS + WIN_IDX_W;

  logic [SAMPLE_BITS-1:0] on_win_r  [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] off_win_r [WINDOW_DEPTH];
  logic [SUM_W-1:0]       on_sum_r, on_sum_nxt;
  logic [SUM_W-1:0]       off_sum_r, off_sum_nxt;
  logic [SUM_W-1:0]       prev_raw_r;
  logic [DELTA_W-1:0]     delta_r;
  logic [HIST_W-1:0]      hist_r;

  logic [SUM_W-1:0]   raw, dmax;
  logic [WIDE_W-1:0]  total, wide;
  logic [DELTA_W-1:0] sat, dsel;
  logic               scale, cliff;

  // running sums: drop the overwritten slot, add the new sample
  assign on_sum_nxt  = on_sum_r - SUM_W'(on_win_r[ctrl.slot]) + SUM_W'(sample);
  assign off_sum_nxt = off_sum_r - SUM_W'(off_win_r[ctrl.slot]) + SUM_W'(sample);

  always_comb begin
    raw   = (off_sum_r >= on_sum_r) ? off_sum_r - on_sum_r : on_sum_r - off_sum_r;
    dmax  = (raw > prev_raw_r) ? raw : prev_raw_r;
    total = WIDE_W'(on_sum_r) + WIDE_W'(off_sum_r);
    scale = (total < DARK_LIMIT) && (THR_W'(dmax) < off_thr);
    wide  = WIDE_W'(dmax) << SCALE_SHIFT;
    sat   = (|wide[WIDE_W-1:DELTA_W]) ? DELTA_MAX : wide[DELTA_W-1:0];
    dsel  = scale ? sat : DELTA_W'(dmax);
    // hysteresis between the two thresholds
    if (THR_W'(dsel) >= on_thr) begin
      cliff = 1'b0;
    end else if (THR_W'(dsel) < off_thr) begin
      cliff = 1'b1;
    end else begin
      cliff = hist_r[0];
    end
    history_nxt = ctrl.eval ? {hist_r[HIST_W-2:0], cliff} : hist_r;
    delta_nxt   = ctrl.eval ? dsel : delta_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        on_win_r[i]  <= '0;
        off_win_r[i] <= '0;
      end
      on_sum_r   <= '0;
      off_sum_r  <= '0;
      prev_raw_r <= '0;
      delta_r    <= '0;
      hist_r     <= '0;
    end else begin
      if (ctrl.take_on) begin
        on_win_r[ctrl.slot] <= sample;
        on_sum_r            <= on_sum_nxt;
      end
      if (ctrl.take_off) begin
        off_win_r[ctrl.slot] <= sample;
        off_sum_r            <= off_sum_nxt;
      end
      if (ctrl.eval) begin
        prev_raw_r <= raw;
      end
      delta_r <= delta_nxt;
      hist_r  <= history_nxt;
    end
  end

endmodule

// File: rtl/icd_out.sv
module icd_out import icd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic                  evaluated,
  input  logic [HIST_W-1:0]     history [LANES],
  input  logic [DELTA_W-1:0]    delta   [LANES],
  output logic                  in_ready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  logic [OUT_DATA_W-1:0] res_data;
  logic [FLAGS_W-1:0]    flags;

  logic                  main_v_r, skid_v_r;
  logic [OUT_DATA_W-1:0] main_data_r, skid_data_r;
  logic                  main_user_r, skid_user_r;
  logic                  pop;

  // merge lane results: flags, then histories, then deltas
  always_comb begin
    res_data = '0;
    for (int c = 0; c < LANES; c++) begin
      flags[c] = |history[c];
      res_data[FLAGS_W + c*HIST_W +: HIST_W]                  = history[c];
      res_data[FLAGS_W + LANES*HIST_W + c*DELTA_W +: DELTA_W] = delta[c];
    end
    res_data[FLAGS_W-1:0] = flags;
  end

  assign pop        = main_v_r && out_tready;
  assign in_ready   = !skid_v_r;
  assign out_tvalid = main_v_r;
  assign out_tdata  = main_data_r;
  assign out_tuser  = main_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (take) begin
      if (!main_v_r || pop) begin
        main_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        main_data_r <= skid_data_r;
        main_user_r <= skid_user_r;
      end
    end else if (take) begin
      if (!main_v_r || pop) begin
        main_data_r <= res_data;
        main_user_r <= evaluated;
      end else begin
        skid_data_r <= res_data;
        skid_user_r <= evaluated;
      end
    end
  end

endmodule

// File: rtl/ir_cliff_detector.sv
// ir cliff detector, four lanes working side by side on the four channels
// each result is registered, into the skid slot if the main slot is held
// one request per cycle while in_tready is high; each gives exactly one result
// a two-entry output buffer lets in_tready stay high while one result waits
// reset: synchronous on rst_n low, clears windows, sums, counts, history,
// deltas and thresholds to zero and empties the output buffer
module ir_cliff_detector import icd_pkg::*; #(
  parameter int unsigned CHANNELS    = CHANNELS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sample_0, sample_1, sample_2, sample_3
  input  logic [1:0]            in_tuser,   // req_type
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // cliff_flags, history_0..3, delta_0..3
  output logic                  out_tuser,  // evaluated
  // threshold writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [THR_W-1:0]      cfg_data
);

  localparam int unsigned LANE_W = $clog2(LANES);

  // threshold registers, on thresholds first, then off thresholds
  logic [THR_W-1:0] on_thr_r  [LANES];
  logic [THR_W-1:0] off_thr_r [LANES];
  logic [LANE_W-1:0] on_sel, off_sel;

  // shared sample counts, one per window kind
  logic [CNT_W-1:0] on_cnt_r, on_cnt_nxt;
  logic [CNT_W-1:0] off_cnt_r, off_cnt_nxt;
  logic             ready_r, ready_nxt;

  logic       take;
  req_t       req;
  lane_ctrl_t ctrl;
  logic       on_full, off_full;

  logic [HIST_W-1:0]  lane_hist  [LANES];
  logic [DELTA_W-1:0] lane_delta [LANES];

  assign take     = in_tvalid && in_tready;
  assign req      = req_t'(in_tuser);
  assign on_full  = (on_cnt_r >= CNT_W'(WINDOW_DEPTH));
  assign off_full = (off_cnt_r >= CNT_W'(WINDOW_DEPTH));

  // ready becomes sticky once the off window has filled
  assign ready_nxt = ready_r || off_full;

  // request decode: a full window wraps back to slot zero
  always_comb begin
    ctrl        = '0;
    on_cnt_nxt  = on_cnt_r;
    off_cnt_nxt = off_cnt_r;
    unique case (req)
      REQ_ON_SAMPLES: begin
        ctrl.take_on = take;
        ctrl.slot    = on_full ? '0 : on_cnt_r[WIN_IDX_W-1:0];
        on_cnt_nxt   = on_full ? CNT_W'(1) : on_cnt_r + CNT_W'(1);
      end
      REQ_OFF_SAMPLES: begin
        ctrl.take_off = take;
        ctrl.slot     = off_full ? '0 : off_cnt_r[WIN_IDX_W-1:0];
        off_cnt_nxt   = off_full ? CNT_W'(1) : off_cnt_r + CNT_W'(1);
      end
      REQ_EVALUATE: begin
        // evaluation only with both windows holding fresh samples
        ctrl.eval = take && on_full && off_full && ready_nxt;
        if (ctrl.eval) begin
          on_cnt_nxt  = '0;
          off_cnt_nxt = '0;
        end
      end
      REQ_IDLE: begin
        ctrl.slot = '0;
      end
      default: begin
        ctrl.slot = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_cnt_r  <= '0;
      off_cnt_r <= '0;
      ready_r   <= 1'b0;
    end else if (take) begin
      on_cnt_r  <= on_cnt_nxt;
      off_cnt_r <= off_cnt_nxt;
      ready_r   <= ready_nxt;
    end
  end

  // lane addressed by a write, relative to each bank base
  assign on_sel  = LANE_W'(cfg_index - REG_ON_BASE);
  assign off_sel = LANE_W'(cfg_index - REG_OFF_BASE);

  // threshold register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < LANES; c++) begin
        on_thr_r[c]  <= '0;
        off_thr_r[c] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index < REG_OFF_BASE) begin
        on_thr_r[on_sel] <= cfg_data;
      end else begin
        off_thr_r[off_sel] <= cfg_data;
      end
    end
  end

  // one lane per active channel, unused lanes read as zero
  for (genvar c = 0; c < LANES; c++) begin : g_lane
    if (c < CHANNELS) begin : g_active
      icd_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .sample      (in_tdata[c*SAMPLE_W +: SAMPLE_BITS]),
        .on_thr      (on_thr_r[c]),
        .off_thr     (off_thr_r[c]),
        .history_nxt (lane_hist[c]),
        .delta_nxt   (lane_delta[c])
      );
    end else begin : g_unused
      assign lane_hist[c]  = '0;
      assign lane_delta[c] = '0;
    end
  end

  // merge lane results and buffer them toward the result stream
  icd_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .evaluated  (ctrl.eval),
    .history    (lane_hist),
    .delta      (lane_delta),
    .in_ready   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
